FILE: src/lzwfwe_pkg.sv
// Shared types and constants for the fixed-width LZW encoder.
// No dependencies; compile first.
package lzwfwe_pkg;

    localparam int BYTE_BITS  = 8;
    localparam int FIRST_FREE = 256;   // first code handed out to a new string
    localparam int OUTQ_DEPTH = 4;     // result queue entries (power of two)

    typedef enum logic [2:0] {
        S_CLEAR,   // sweep the bucket table after reset
        S_IDLE,    // wait for a source byte
        S_HEAD,    // bucket head arrives from memory
        S_WALK,    // dictionary entry arrives, compare key, follow link
        S_MISS,    // emit prefix, add the new string
        S_FINAL    // emit the last code of the block, drop the dictionary
    } t_state;

endpackage

FILE: src/lzwfwe_if.sv
// Valid/ready channel interfaces for the LZW encoder: byte input, code output.
// Depends on nothing.
interface lzwfwe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       block_end;

    modport source (output valid, output data_byte, output block_end, input ready);
    modport sink   (input valid, input data_byte, input block_end, output ready);
endinterface

interface lzwfwe_out_if #(
    parameter int CODE_BITS = 12
);
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] out_code;
    logic                 final_code;

    modport source (output valid, output out_code, output final_code, input ready);
    modport sink   (input valid, input out_code, input final_code, output ready);
endinterface

FILE: src/lzwfwe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lzwfwe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/lzwfwe_outq.sv
// Small result queue that drives the code output channel.
// Depends on lzwfwe_pkg and lzwfwe_out_if.
module lzwfwe_outq #(
    parameter int CODE_BITS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [CODE_BITS-1:0] i_code,
    input  logic                 i_final,
    output logic                 o_room2,
    lzwfwe_out_if.source         o_out
);
    import lzwfwe_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    logic [CODE_BITS-1:0] r_code  [OUTQ_DEPTH];
    logic                 r_final [OUTQ_DEPTH];
    logic [PW-1:0]        r_wptr, n_wptr;
    logic [PW-1:0]        r_rptr, n_rptr;
    logic [CW-1:0]        r_count, n_count;
    logic                 pop;

    assign pop = o_out.valid && o_out.ready;

    always_comb begin
        n_wptr  = i_push ? r_wptr + PW'(1) : r_wptr;
        n_rptr  = pop ? r_rptr + PW'(1) : r_rptr;
        n_count = r_count + CW'(i_push) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
        if (i_push) begin
            r_code[r_wptr]  <= i_code;
            r_final[r_wptr] <= i_final;
        end
    end

    assign o_room2          = r_count <= CW'(OUTQ_DEPTH - 2);
    assign o_out.valid      = r_count != '0;
    assign o_out.out_code   = r_code[r_rptr];
    assign o_out.final_code = r_final[r_rptr];

endmodule

FILE: src/lzw_fixed_width_encoder.sv
// Fixed-width LZW encoder: hash-chained dictionary walked by one key comparator.
// Depends on lzwfwe_pkg, lzwfwe_if, lzwfwe_ram, lzwfwe_outq.
//
//  channel  dir  handshake    payload
//  i_in     in   valid/ready  data_byte[7:0], block_end
//  o_out    out  valid/ready  out_code[CODE_BITS-1:0], final_code
//
// After reset the bucket table is swept to empty, bucket by bucket, with i_in.ready low.
// The first byte of a block only opens the prefix (and emits it if it also ends the block).
// Any other byte reads its bucket head, then compares chain entries one at a time through
// the dictionary RAM's single read port; a miss emits the prefix and adds the new string
// while codes remain, and a block end emits the last code. Results wait in a 4-entry queue,
// so o_out stalls hold back i_in only once fewer than two slots are free.
module lzw_fixed_width_encoder #(
    parameter int CODE_BITS    = 12,
    parameter int DICT_ENTRIES = 4096,
    parameter int HASH_BUCKETS = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lzwfwe_in_if.sink    i_in,
    lzwfwe_out_if.source o_out
);
    import lzwfwe_pkg::*;

    // Widths: code index, link (holds the empty marker), bucket index, key.
    localparam int IW  = $clog2(DICT_ENTRIES);
    localparam int LW  = $clog2(DICT_ENTRIES + 1);
    localparam int HW  = $clog2(HASH_BUCKETS);
    localparam int KW  = IW + BYTE_BITS;
    localparam int DW  = KW + LW;
    localparam int NCH = (KW + HW - 1) / HW;

    localparam logic [LW-1:0] EMPTY     = LW'(DICT_ENTRIES);
    localparam logic [LW-1:0] FIRST     = LW'(FIRST_FREE);
    localparam logic [HW:0]   BUCKETS_W = (HW + 1)'(HASH_BUCKETS);
    localparam logic [HW-1:0] LAST_BKT  = HW'(HASH_BUCKETS - 1);

    // Fold the key into a bucket index, then one conditional subtract.
    function automatic logic [HW-1:0] f_hash(input logic [KW-1:0] key);
        logic [HW-1:0] acc;
        logic [HW:0]   wide;
        acc = '0;
        for (int i = 0; i < NCH; i++) begin
            acc = acc ^ HW'(key >> (i * HW));
        end
        wide = {1'b0, acc};
        if (wide >= BUCKETS_W) begin
            wide = wide - BUCKETS_W;
        end
        return wide[HW-1:0];
    endfunction

    // Link stored with a new entry: the old head if live, else the empty marker.
    function automatic logic [LW-1:0] head_live_at_miss(input logic [LW-1:0] head,
                                                        input logic [LW-1:0] nf);
        return (head < nf) ? head : EMPTY;
    endfunction

    t_state        r_state, n_state;
    logic [IW-1:0] r_prefix, n_prefix;
    logic          r_prefix_valid, n_prefix_valid;
    logic [LW-1:0] r_nf, n_nf;           // next free code
    logic [7:0]    r_ch, n_ch;
    logic          r_last, n_last;
    logic [HW-1:0] r_bucket, n_bucket;
    logic [LW-1:0] r_head, n_head;
    logic [IW-1:0] r_cur, n_cur;         // code whose entry is being compared
    logic [HW-1:0] r_clr, n_clr;

    // Memory ports
    logic          hd_we;
    logic [HW-1:0] hd_waddr, hd_raddr;
    logic [LW-1:0] hd_wdata, hd_rdata;
    logic          dc_we;
    logic [IW-1:0] dc_waddr, dc_raddr;
    logic [DW-1:0] dc_wdata, dc_rdata;

    // Queue push
    logic                 push;
    logic                 push_final;
    logic [CODE_BITS-1:0] push_code;
    logic                 room2;

    logic          accept;
    logic [KW-1:0] cur_key;
    logic [KW-1:0] ent_key;
    logic [LW-1:0] ent_link;
    logic          head_live;
    logic          key_hit;
    logic          link_live;

    assign i_in.ready = (r_state == S_IDLE) && room2;
    assign accept     = i_in.valid && i_in.ready;

    assign cur_key  = {r_prefix, r_ch};
    assign ent_key  = dc_rdata[DW-1:LW];
    assign ent_link = dc_rdata[LW-1:0];
    // A head or link at or above the next free code belongs to an earlier
    // block (or is the empty marker): treat it as empty.
    assign head_live = hd_rdata < r_nf;
    assign key_hit   = ent_key == cur_key;
    assign link_live = ent_link < r_nf;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == LAST_BKT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (!r_prefix_valid) begin
                        n_state = i_in.block_end ? S_FINAL : S_IDLE;
                    end else begin
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                n_state = head_live ? S_WALK : S_MISS;
            end
            S_WALK: begin
                if (key_hit) begin
                    n_state = r_last ? S_FINAL : S_IDLE;
                end else if (!link_live) begin
                    n_state = S_MISS;
                end
            end
            S_MISS: begin
                n_state = r_last ? S_FINAL : S_IDLE;
            end
            S_FINAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath control and register updates
    always_comb begin
        n_prefix       = r_prefix;
        n_prefix_valid = r_prefix_valid;
        n_nf           = r_nf;
        n_ch           = r_ch;
        n_last         = r_last;
        n_bucket       = r_bucket;
        n_head         = r_head;
        n_cur          = r_cur;
        n_clr          = r_clr;
        hd_we          = 1'b0;
        hd_waddr       = r_bucket;
        hd_wdata       = r_nf;
        hd_raddr       = f_hash({r_prefix, i_in.data_byte});
        dc_we          = 1'b0;
        dc_waddr       = r_nf[IW-1:0];
        dc_wdata       = {cur_key, head_live_at_miss(r_head, r_nf)};
        dc_raddr       = r_cur;
        push           = 1'b0;
        push_final     = 1'b0;
        push_code      = CODE_BITS'(r_prefix);
        case (r_state)
            S_CLEAR: begin
                hd_we    = 1'b1;
                hd_waddr = r_clr;
                hd_wdata = EMPTY;
                n_clr    = r_clr + HW'(1);
            end
            S_IDLE: begin
                if (accept) begin
                    n_ch     = i_in.data_byte;
                    n_last   = i_in.block_end;
                    n_bucket = hd_raddr;
                    if (!r_prefix_valid) begin
                        // First byte of a block opens the prefix.
                        n_prefix       = IW'(i_in.data_byte);
                        n_prefix_valid = 1'b1;
                    end
                end
            end
            S_HEAD: begin
                n_head   = hd_rdata;
                dc_raddr = hd_rdata[IW-1:0];
                n_cur    = hd_rdata[IW-1:0];
            end
            S_WALK: begin
                if (key_hit) begin
                    n_prefix = r_cur;
                end else begin
                    dc_raddr = ent_link[IW-1:0];
                    n_cur    = ent_link[IW-1:0];
                end
            end
            S_MISS: begin
                push = 1'b1;
                if (r_nf < EMPTY) begin
                    // Add the new string at the chain front of its bucket.
                    dc_we = 1'b1;
                    hd_we = 1'b1;
                    n_nf  = r_nf + LW'(1);
                end
                n_prefix = IW'(r_ch);
            end
            S_FINAL: begin
                push           = 1'b1;
                push_final     = 1'b1;
                n_prefix       = '0;
                n_prefix_valid = 1'b0;
                n_nf           = FIRST;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_prefix_valid <= 1'b0;
            r_nf           <= FIRST;
            r_clr          <= '0;
            r_prefix       <= '0;
        end else begin
            r_state        <= n_state;
            r_prefix_valid <= n_prefix_valid;
            r_nf           <= n_nf;
            r_clr          <= n_clr;
            r_prefix       <= n_prefix;
        end
        r_ch     <= n_ch;
        r_last   <= n_last;
        r_bucket <= n_bucket;
        r_head   <= n_head;
        r_cur    <= n_cur;
    end

    // Bucket heads: newest code per bucket.
    lzwfwe_ram #(
        .WIDTH (LW),
        .DEPTH (HASH_BUCKETS)
    ) u_heads (
        .i_clk   (i_clk),
        .i_we    (hd_we),
        .i_waddr (hd_waddr),
        .i_wdata (hd_wdata),
        .i_raddr (hd_raddr),
        .o_rdata (hd_rdata)
    );

    // Dictionary: {prefix, byte, chain link} per code.
    lzwfwe_ram #(
        .WIDTH (DW),
        .DEPTH (DICT_ENTRIES)
    ) u_dict (
        .i_clk   (i_clk),
        .i_we    (dc_we),
        .i_waddr (dc_waddr),
        .i_wdata (dc_wdata),
        .i_raddr (dc_raddr),
        .o_rdata (dc_rdata)
    );

    lzwfwe_outq #(
        .CODE_BITS (CODE_BITS)
    ) u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_code  (push_code),
        .i_final (push_final),
        .o_room2 (room2),
        .o_out   (o_out)
    );

    // Next free code stays within the code space.
    a_nf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_nf >= FIRST) && (r_nf <= EMPTY))
        else $error("next free code out of range");

    // The walk only visits codes handed out in this block.
    a_walk_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (LW'(r_cur) < r_nf))
        else $error("chain walk reached an unassigned code");

    // No byte is taken while the bucket sweep runs.
    a_clear_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_in.ready)
        else $error("input ready during bucket sweep");

    // The last code of a block drops the prefix and the dictionary.
    a_block_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && push_final) |=> (!r_prefix_valid && (r_nf == FIRST)))
        else $error("dictionary not dropped after block end");

endmodule
